>>> rtl/presence_slideshow_controller_unit_macros.svh
// Assertion macros shared by the presence slideshow controller RTL.
`ifndef PRESENCE_SLIDESHOW_CONTROLLER_UNIT_MACROS_SVH
`define PRESENCE_SLIDESHOW_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define PSC_ASSERT_IMPLIES(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed: lbl");
// Next-cycle implication, checked outside reset.
`define PSC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed: lbl");
`else
`define PSC_ASSERT_IMPLIES(lbl, pre, post)
`define PSC_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> rtl/psc_pkg.sv
// Shared types, register codes and constants of the presence slideshow controller.
package psc_pkg;

  // Upper bound on the number of images that can be cycled through
  localparam int unsigned MAX_IMAGES = 8;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PRESENCE_CONFIRM = 3'd0,
    REG_VACANCY_CONFIRM  = 3'd1,
    REG_HOLD_TICKS       = 3'd2,
    REG_SLIDESHOW_TICKS  = 3'd3,
    REG_IMAGE_COUNT      = 3'd4,
    REG_SHAKE_LEVEL      = 3'd5,
    REG_SHAKE_COOLDOWN   = 3'd6,
    REG_NEXT_COMMAND     = 3'd7
  } cfg_reg_e;

  // Configuration register file
  typedef struct packed {
    logic [7:0]  presence_confirm_ticks;
    logic [7:0]  vacancy_confirm_ticks;
    logic [15:0] hold_ticks;
    logic [15:0] slideshow_ticks;
    logic [3:0]  image_count;
    logic [15:0] shake_level;
    logic [15:0] shake_cooldown_ticks;
    logic [7:0]  next_command_code;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    presence_confirm_ticks: 8'd5,
    vacancy_confirm_ticks:  8'd10,
    hold_ticks:             16'd2000,
    slideshow_ticks:        16'd200,
    image_count:            4'd6,
    shake_level:            16'd4000,
    shake_cooldown_ticks:   16'd80,
    next_command_code:      8'd1
  };

  // Effective image count: clamp to the supported range, zero acts like one
  function automatic logic [3:0] image_limit(input logic [3:0] cnt);
    logic [3:0] n;
    n = cnt;
    if (int'(n) > MAX_IMAGES) n = 4'(MAX_IMAGES);
    if (n > 4'd8) n = 4'd8;
    if (n == 4'd0) n = 4'd1;
    return n;
  endfunction

endpackage

>>> rtl/psc_debounce.sv
// Motion sensor debouncer: saturating run counters and the stable presence flag.
module psc_debounce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          motion_i,
  input  logic          mode_i,
  input  logic          clr_i,
  input  psc_pkg::cfg_t cfg_i,
  output logic          stable_o
);
  import psc_pkg::*;

  logic [7:0] present_run_q, present_run_d;
  logic [7:0] absent_run_q, absent_run_d;
  logic       stable_q, stable_mid;
  logic [7:0] pres_lim, vac_lim;
  logic [8:0] pres_inc, abs_inc;

  assign pres_lim = (cfg_i.presence_confirm_ticks == 8'd0) ? 8'd1 : cfg_i.presence_confirm_ticks;
  assign vac_lim  = (cfg_i.vacancy_confirm_ticks == 8'd0) ? 8'd1 : cfg_i.vacancy_confirm_ticks;
  assign pres_inc = {1'b0, present_run_q} + 9'd1;
  assign abs_inc  = {1'b0, absent_run_q} + 9'd1;

  // Advance the run counters for this tick
  always_comb begin
    present_run_d = present_run_q;
    absent_run_d  = absent_run_q;
    stable_mid    = stable_q;
    if (motion_i) begin
      absent_run_d = '0;
      if (pres_inc >= {1'b0, pres_lim}) begin
        present_run_d = pres_lim;
        stable_mid    = 1'b1;
      end else begin
        present_run_d = pres_inc[7:0];
      end
    end else if (!mode_i) begin
      present_run_d = '0;
      if (abs_inc >= {1'b0, vac_lim}) begin
        absent_run_d = vac_lim;
        stable_mid   = 1'b0;
      end else begin
        absent_run_d = abs_inc[7:0];
      end
    end else begin
      present_run_d = '0;
    end
  end

  assign stable_o = stable_mid;

  // Hold state; drop stable presence when presence mode ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_run_q <= '0;
      absent_run_q  <= '0;
      stable_q      <= 1'b0;
    end else if (en_i) begin
      present_run_q <= present_run_d;
      absent_run_q  <= clr_i ? 8'd0 : absent_run_d;
      stable_q      <= clr_i ? 1'b0 : stable_mid;
    end
  end

endmodule

>>> rtl/psc_shake.sv
// Shake detector: per-axis change against a threshold, then a cooldown.
module psc_shake (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               accel_valid_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  psc_pkg::cfg_t      cfg_i,
  output logic               fire_o
);
  import psc_pkg::*;

  logic signed [15:0] prev_x_q, prev_y_q, prev_z_q;
  logic               first_q;
  logic [15:0]        cooldown_q, cooldown_dec, cooldown_d;
  logic [16:0]        dx, dy, dz;
  logic               big;

  // Absolute difference of two samples, at most 65535
  function automatic logic [16:0] absdiff(input logic signed [15:0] a,
                                           input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    return d[16] ? 17'(-d) : 17'(d);
  endfunction

  assign dx  = absdiff(accel_x_i, prev_x_q);
  assign dy  = absdiff(accel_y_i, prev_y_q);
  assign dz  = absdiff(accel_z_i, prev_z_q);
  assign big = (dx > {1'b0, cfg_i.shake_level}) ||
               (dy > {1'b0, cfg_i.shake_level}) ||
               (dz > {1'b0, cfg_i.shake_level});

  // Count the cooldown down on each sample, fire on a large change once it has run out
  always_comb begin
    cooldown_dec = (cooldown_q != 16'd0) ? cooldown_q - 16'd1 : cooldown_q;
    fire_o       = accel_valid_i && !first_q && big && (cooldown_dec == 16'd0);
    cooldown_d   = fire_o ? cfg_i.shake_cooldown_ticks : cooldown_dec;
  end

  // Hold the previous sample and the cooldown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q   <= '0;
      prev_y_q   <= '0;
      prev_z_q   <= '0;
      first_q    <= 1'b1;
      cooldown_q <= '0;
    end else if (en_i && accel_valid_i) begin
      prev_x_q   <= accel_x_i;
      prev_y_q   <= accel_y_i;
      prev_z_q   <= accel_z_i;
      first_q    <= 1'b0;
      cooldown_q <= cooldown_d;
    end
  end

endmodule

>>> rtl/presence_slideshow_controller_unit.sv
// Top level of the presence slideshow controller: config, tick pipeline and mode logic.
//
// Usage:
//   Each input request is one 10 ms tick: motion bit, optional accelerometer
//   sample (accel_valid_i) and optional voice command (voice_valid_i).
//   Each tick yields exactly one result: image index, refresh flag, presence
//   mode flag and shake flag. Both channels use valid/stall; a request moves
//   on a rising edge with valid high and stall low.
//   A request accepted into the input register moves into the result register
//   and shows on the output when the output side is not stalled.
//   Throughput: one request per cycle without stalls; the whole tick update is
//   one pass of compare and counter logic between input and result register.
//   When the receiver stalls, the result register holds; an empty input
//   register still takes one request, and once it is full in_stall_o rises.
//   Reset (rst_ni low, asynchronous) empties both registers, restores all
//   configuration registers to their defaults and clears the tick state
//   (slideshow mode, image 0, no sample seen yet).
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i at the
//   clock edge; write only while the block is idle.
`include "presence_slideshow_controller_unit_macros.svh"

module presence_slideshow_controller_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  psc_pkg::cfg_reg_e  cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // tick requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               motion_present_i,
  input  logic               accel_valid_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic               voice_valid_i,
  input  logic [7:0]         voice_code_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         image_index_o,
  output logic               image_refresh_o,
  output logic               presence_mode_o,
  output logic               shake_seen_o
);
  import psc_pkg::*;

  cfg_t cfg_q;

  // input register
  logic               in_valid_q;
  logic               motion_q, accel_valid_q, voice_valid_q;
  logic signed [15:0] accel_x_q, accel_y_q, accel_z_q;
  logic [7:0]         voice_code_q;

  // result register
  logic       out_valid_q;
  logic [2:0] image_out_q;
  logic       refresh_out_q, mode_out_q, shake_out_q;

  // mode state
  logic [2:0]  image_q, image_d;
  logic [15:0] hold_q, hold_d, hold_mid;
  logic [15:0] slide_q, slide_d;
  logic        mode_q, mode_d;

  logic        in_accept, advance, load;
  logic        stable, shake, voice_next, refresh, clr;
  logic [3:0]  img_lim, img_inc;
  logic [2:0]  img_next;
  logic [15:0] slide_lim;
  logic [16:0] slide_inc;

  // Handshake: the input register moves on when the result register frees up
  assign advance    = !out_valid_q || !out_stall_i;
  assign load       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PRESENCE_CONFIRM: cfg_q.presence_confirm_ticks <= cfg_data_i[7:0];
        REG_VACANCY_CONFIRM:  cfg_q.vacancy_confirm_ticks  <= cfg_data_i[7:0];
        REG_HOLD_TICKS:       cfg_q.hold_ticks             <= cfg_data_i;
        REG_SLIDESHOW_TICKS:  cfg_q.slideshow_ticks        <= cfg_data_i;
        REG_IMAGE_COUNT:      cfg_q.image_count            <= cfg_data_i[3:0];
        REG_SHAKE_LEVEL:      cfg_q.shake_level            <= cfg_data_i;
        REG_SHAKE_COOLDOWN:   cfg_q.shake_cooldown_ticks   <= cfg_data_i;
        REG_NEXT_COMMAND:     cfg_q.next_command_code      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      motion_q      <= motion_present_i;
      accel_valid_q <= accel_valid_i;
      accel_x_q     <= accel_x_i;
      accel_y_q     <= accel_y_i;
      accel_z_q     <= accel_z_i;
      voice_valid_q <= voice_valid_i;
      voice_code_q  <= voice_code_i;
    end
  end

  psc_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (load),
    .motion_i (motion_q),
    .mode_i   (mode_q),
    .clr_i    (clr),
    .cfg_i    (cfg_q),
    .stable_o (stable)
  );

  psc_shake u_shake (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (load),
    .accel_valid_i (accel_valid_q),
    .accel_x_i     (accel_x_q),
    .accel_y_i     (accel_y_q),
    .accel_z_i     (accel_z_q),
    .cfg_i         (cfg_q),
    .fire_o        (shake)
  );

  assign voice_next = voice_valid_q && (voice_code_q == cfg_q.next_command_code);

  // Next image with wrap at the effective image count
  assign img_lim  = image_limit(cfg_q.image_count);
  assign img_inc  = {1'b0, image_q} + 4'd1;
  assign img_next = (img_inc >= img_lim) ? 3'd0 : img_inc[2:0];

  assign slide_lim = (cfg_q.slideshow_ticks == 16'd0) ? 16'd1 : cfg_q.slideshow_ticks;
  assign slide_inc = {1'b0, slide_q} + 17'd1;
  assign hold_mid  = stable ? cfg_q.hold_ticks : hold_q - 16'd1;

  // Mode logic: presence mode, entry on stable presence, slideshow otherwise
  always_comb begin
    image_d = image_q;
    hold_d  = hold_q;
    slide_d = slide_q;
    mode_d  = mode_q;
    refresh = 1'b0;
    clr     = 1'b0;
    if (mode_q) begin
      hold_d = hold_mid;
      if (shake || voice_next) begin
        image_d = img_next;
        refresh = 1'b1;
      end
      if (hold_mid == 16'd0) begin
        mode_d  = 1'b0;
        slide_d = '0;
        clr     = 1'b1;
      end
    end else if (stable) begin
      image_d = '0;
      refresh = 1'b1;
      mode_d  = 1'b1;
      hold_d  = cfg_q.hold_ticks;
    end else if (slide_inc >= {1'b0, slide_lim}) begin
      image_d = img_next;
      refresh = 1'b1;
      slide_d = '0;
    end else begin
      slide_d = slide_inc[15:0];
    end
  end

  // Hold mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q <= '0;
      hold_q  <= '0;
      slide_q <= '0;
      mode_q  <= 1'b0;
    end else if (load) begin
      image_q <= image_d;
      hold_q  <= hold_d;
      slide_q <= slide_d;
      mode_q  <= mode_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      image_out_q   <= image_d;
      refresh_out_q <= refresh;
      mode_out_q    <= mode_d;
      shake_out_q   <= shake;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign image_index_o   = image_out_q;
  assign image_refresh_o = refresh_out_q;
  assign presence_mode_o = mode_out_q;
  assign shake_seen_o    = shake_out_q;

  // Checks
  `PSC_ASSERT_IMPLIES(a_stall_needs_item, in_stall_o, in_valid_q)
  `PSC_ASSERT_NEXT(a_load_fills_result, load, out_valid_q)
  `PSC_ASSERT_IMPLIES(a_entry_shows_first, load && !mode_q && mode_d, image_d == 3'd0 && refresh)
  `PSC_ASSERT_IMPLIES(a_image_change_refresh, load && (image_d != image_q), refresh)

endmodule

>>> dv/tb_presence_slideshow_controller_unit.sv
`timescale 1ns / 100ps
// Testbench of the presence slideshow controller: directed table, random phases, scoreboard.
module tb_presence_slideshow_controller_unit;
  import psc_pkg::*;

  // One tick request and one result, at the block's widths
  typedef struct packed {
    logic               motion;
    logic               accel_valid;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               voice_valid;
    logic [7:0]         voice_code;
  } tick_t;

  typedef struct packed {
    logic [2:0] image_index;
    logic       image_refresh;
    logic       presence_mode;
    logic       shake_seen;
  } res_t;

  typedef struct packed {
    tick_t tick;
    logic  typed;
    res_t  want;
  } dir_row_t;

  localparam int DIR_ROWS = 22;
  localparam int PHASES = 8;
  localparam int PHASE_TICKS = 50;
  localparam int HOLD_OFF_CYCLES = 40;

  // Directed ticks, run with the reset configuration. Rows with typed set carry
  // an expectation written by hand; the rest use the predictor.
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // first sample only stored, at the axis extremes
    '{'{1'b0, 1'b1, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    // full-scale swing fires a shake outside presence mode, image unchanged
    '{'{1'b0, 1'b1, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b1}},
    // cooldown blocks the next swing
    '{'{1'b0, 1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    // next-image command ignored in slideshow mode
    '{'{1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    // present readings below the confirm count
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0}},
    // stable presence enters presence mode on image 0
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}, 1'b1, '{3'd0, 1'b1, 1'b1, 1'b0}},
    // next-image command advances
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b1, '{3'd1, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'hFF}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h01}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h00}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'h00}, 1'b0, '0},
    // walk the index up to the wrap
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b0, '0},
    '{'{1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01}, 1'b0, '0},
    '{'{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'h01}, 1'b0, '0},
    '{'{1'b1, 1'b1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 8'hAA}, 1'b0, '0},
    '{'{1'b0, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 8'h55}, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  cfg_reg_e           cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               motion_present_i;
  logic               accel_valid_i;
  logic signed [15:0] accel_x_i;
  logic signed [15:0] accel_y_i;
  logic signed [15:0] accel_z_i;
  logic               voice_valid_i;
  logic [7:0]         voice_code_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         image_index_o;
  logic               image_refresh_o;
  logic               presence_mode_o;
  logic               shake_seen_o;

  presence_slideshow_controller_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .motion_present_i (motion_present_i),
    .accel_valid_i    (accel_valid_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .voice_valid_i    (voice_valid_i),
    .voice_code_i     (voice_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .image_index_o    (image_index_o),
    .image_refresh_o  (image_refresh_o),
    .presence_mode_o  (presence_mode_o),
    .shake_seen_o     (shake_seen_o)
  );

  // Shadow configuration and frame state of the predictor
  cfg_t               cfg_shadow = CfgReset;
  logic [2:0]         show_idx = '0;
  logic [15:0]        hold_left = '0;
  logic [15:0]        slide_left = '0;
  logic [7:0]         seen_run = '0;
  logic [7:0]         empty_run = '0;
  logic               seen_stable = 1'b0;
  logic               in_presence = 1'b0;
  logic signed [15:0] last_x = '0;
  logic signed [15:0] last_y = '0;
  logic signed [15:0] last_z = '0;
  logic               no_sample_yet = 1'b1;
  logic [15:0]        cool_left = '0;

  res_t frame_results_q [$];
  int   mismatches = 0;

  // Handshake pacing
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  logic press_on = 1'b0;
  logic hold_off_req = 1'b0;

  // Random tick generator state
  int unsigned        run_left = 0;
  logic               run_motion = 1'b0;
  logic signed [15:0] drive_x = '0;
  logic signed [15:0] drive_y = '0;
  logic signed [15:0] drive_z = '0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int abs_delta(logic signed [15:0] a, logic signed [15:0] b);
    int d;
    d = int'(a) - int'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Advance the shown image, wrapping at the effective image count
  function automatic void next_image();
    int n;
    n = int'(cfg_shadow.image_count);
    if (n > int'(MAX_IMAGES)) n = int'(MAX_IMAGES);
    if (n > 8) n = 8;
    if (n == 0) n = 1;
    if (int'(show_idx) + 1 >= n) show_idx = '0;
    else show_idx = show_idx + 3'd1;
  endfunction

  // Predict the result of one tick and update the shadow state
  function automatic res_t frame_step(tick_t t);
    int   lim;
    int   cnt;
    int   th;
    logic fire;
    logic refresh;
    logic voice_next;
    logic big;
    res_t r;
    fire = 1'b0;
    refresh = 1'b0;

    // debounce motion
    if (t.motion) begin
      lim = (cfg_shadow.presence_confirm_ticks == 0) ? 1 : int'(cfg_shadow.presence_confirm_ticks);
      empty_run = '0;
      if (int'(seen_run) + 1 >= lim) begin
        seen_run = 8'(lim);
        seen_stable = 1'b1;
      end else begin
        seen_run = seen_run + 8'd1;
      end
    end else if (!in_presence) begin
      lim = (cfg_shadow.vacancy_confirm_ticks == 0) ? 1 : int'(cfg_shadow.vacancy_confirm_ticks);
      seen_run = '0;
      if (int'(empty_run) + 1 >= lim) begin
        empty_run = 8'(lim);
        seen_stable = 1'b0;
      end else begin
        empty_run = empty_run + 8'd1;
      end
    end else begin
      seen_run = '0;
    end

    // detect shake on valid samples
    if (t.accel_valid) begin
      if (cool_left != 0) cool_left = cool_left - 16'd1;
      if (no_sample_yet) begin
        no_sample_yet = 1'b0;
      end else begin
        th = int'(cfg_shadow.shake_level);
        big = abs_delta(t.ax, last_x) > th || abs_delta(t.ay, last_y) > th ||
              abs_delta(t.az, last_z) > th;
        if (big && cool_left == 0) begin
          cool_left = cfg_shadow.shake_cooldown_ticks;
          fire = 1'b1;
        end
      end
      last_x = t.ax;
      last_y = t.ay;
      last_z = t.az;
    end

    voice_next = t.voice_valid && (t.voice_code == cfg_shadow.next_command_code);

    // mode logic
    if (in_presence) begin
      if (seen_stable) hold_left = cfg_shadow.hold_ticks;
      else hold_left = hold_left - 16'd1;
      if (fire || voice_next) begin
        next_image();
        refresh = 1'b1;
      end
      if (hold_left == 0) begin
        in_presence = 1'b0;
        slide_left = '0;
        seen_stable = 1'b0;
        empty_run = '0;
      end
    end else if (seen_stable) begin
      show_idx = '0;
      refresh = 1'b1;
      in_presence = 1'b1;
      hold_left = cfg_shadow.hold_ticks;
    end else begin
      cnt = int'(slide_left) + 1;
      lim = (cfg_shadow.slideshow_ticks == 0) ? 1 : int'(cfg_shadow.slideshow_ticks);
      if (cnt >= lim) begin
        next_image();
        refresh = 1'b1;
        slide_left = '0;
      end else begin
        slide_left = 16'(cnt);
      end
    end

    r.image_index = show_idx;
    r.image_refresh = refresh;
    r.presence_mode = in_presence;
    r.shake_seen = fire;
    return r;
  endfunction

  // Mostly small jitter, sometimes a jump or a rail
  function automatic logic signed [15:0] next_axis(logic signed [15:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return prev + 16'($urandom_range(0, 600)) - 16'd300;
      6, 7:             return 16'($urandom);
      8:                return 16'h8000;
      default:          return 16'h7FFF;
    endcase
  endfunction

  // Motion in runs with some noise, samples and commands at random
  function automatic tick_t random_tick();
    tick_t t;
    if (run_left == 0) begin
      run_motion = 1'($urandom_range(0, 1));
      run_left = $urandom_range(1, 20);
    end
    run_left = run_left - 1;
    drive_x = next_axis(drive_x);
    drive_y = next_axis(drive_y);
    drive_z = next_axis(drive_z);
    t.motion = ($urandom_range(0, 11) == 0) ? !run_motion : run_motion;
    t.accel_valid = ($urandom_range(0, 9) < 7);
    t.ax = drive_x;
    t.ay = drive_y;
    t.az = drive_z;
    t.voice_valid = ($urandom_range(0, 3) == 0);
    t.voice_code = ($urandom_range(0, 4) < 3) ? cfg_shadow.next_command_code : 8'($urandom);
    return t;
  endfunction

  // Configuration value biased toward the edges and small counts
  function automatic logic [15:0] pick_val(int unsigned hi);
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return 16'd1;
      3:       return 16'(hi);
      4, 5, 6: return 16'($urandom_range(2, 12));
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  // Write one register; leaves the write enable high for a following write
  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_PRESENCE_CONFIRM: cfg_shadow.presence_confirm_ticks = data[7:0];
      REG_VACANCY_CONFIRM:  cfg_shadow.vacancy_confirm_ticks = data[7:0];
      REG_HOLD_TICKS:       cfg_shadow.hold_ticks = data;
      REG_SLIDESHOW_TICKS:  cfg_shadow.slideshow_ticks = data;
      REG_IMAGE_COUNT:      cfg_shadow.image_count = data[3:0];
      REG_SHAKE_LEVEL:      cfg_shadow.shake_level = data;
      REG_SHAKE_COOLDOWN:   cfg_shadow.shake_cooldown_ticks = data;
      REG_NEXT_COMMAND:     cfg_shadow.next_command_code = data[7:0];
      default: ;
    endcase
  endtask

  // Phase 0 writes the lowest values, phase 1 the highest, later phases mix
  task automatic configure(input int ph);
    logic [15:0] v [8];
    for (int k = 0; k < 8; k++) begin
      v[k] = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : pick_val((k == 4) ? 15 : 65535);
    end
    // junk in the unused upper bits of the narrow registers
    write_reg(REG_PRESENCE_CONFIRM, {8'($urandom), v[0][7:0]});
    write_reg(REG_VACANCY_CONFIRM,  {8'($urandom), v[1][7:0]});
    write_reg(REG_HOLD_TICKS,       v[2]);
    write_reg(REG_SLIDESHOW_TICKS,  v[3]);
    write_reg(REG_IMAGE_COUNT,      {12'($urandom), v[4][3:0]});
    write_reg(REG_SHAKE_LEVEL,      v[5]);
    write_reg(REG_SHAKE_COOLDOWN,   v[6]);
    write_reg(REG_NEXT_COMMAND,     {8'($urandom), v[7][7:0]});
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick request after a random gap and record its expected result
  task automatic send_tick(input tick_t t, input logic typed, input res_t want);
    int unsigned gap;
    res_t        pred;
    gap = (send_calm || press_on) ? 0 : $urandom_range(0, 9);
    if ($urandom_range(0, 14) == 0) send_calm = !send_calm;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    motion_present_i <= t.motion;
    accel_valid_i <= t.accel_valid;
    accel_x_i <= t.ax;
    accel_y_i <= t.ay;
    accel_z_i <= t.az;
    voice_valid_i <= t.voice_valid;
    voice_code_i <= t.voice_code;
    do @(posedge clk_i); while (in_stall_o);
    pred = frame_step(t);
    frame_results_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain_ticks();
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_PRESENCE_CONFIRM;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    motion_present_i = 1'b0;
    accel_valid_i = 1'b0;
    accel_x_i = '0;
    accel_y_i = '0;
    accel_z_i = '0;
    voice_valid_i = 1'b0;
    voice_code_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_tick(DIR_TAB[i].tick, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_ticks();
      configure(ph);
      // one phase runs back to back against a long receiver hold-off
      press_on = (ph == 2);
      if (press_on) hold_off_req = 1'b1;
      repeat (PHASE_TICKS) send_tick(random_tick(), 1'b0, '0);
    end
    press_on = 1'b0;
    drain_ticks();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles per result, once a long stretch
  initial begin
    int unsigned wait_cycles;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cycles = HOLD_OFF_CYCLES;
      end else begin
        wait_cycles = recv_calm ? 0 : $urandom_range(0, 9);
      end
      if ($urandom_range(0, 14) == 0) recv_calm = !recv_calm;
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, actual image %0d refresh %0b mode %0b shake %0b",
                 $time, image_index_o, image_refresh_o, presence_mode_o, shake_seen_o);
      end else begin
        want = frame_results_q.pop_front();
        check_field("image_index", int'(want.image_index), int'(image_index_o));
        check_field("image_refresh", int'(want.image_refresh), int'(image_refresh_o));
        check_field("presence_mode", int'(want.presence_mode), int'(presence_mode_o));
        check_field("shake_seen", int'(want.shake_seen), int'(shake_seen_o));
      end
    end
  end

  // Watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_debounce.sv
rtl/psc_shake.sv
rtl/presence_slideshow_controller_unit.sv
dv/tb_presence_slideshow_controller_unit.sv
